// ===== hw/rtl/ardec_pkg.sv =====
// ----------------------------------------------------------------------------
// ardec_pkg
// Types and constants shared by the archive directory decoder.
// ----------------------------------------------------------------------------
package ardec_pkg;

  localparam logic [31:0] MAGIC_ENCRYPTED = 32'h454F_4146;
  localparam logic [31:0] MAGIC_PLAIN     = 32'h0032_5352;
  localparam logic [7:0]  KEY_XOR         = 8'h52;
  localparam logic [1:0]  FIELD_LAST_BYTE = 2'd3;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_HEADER  = 4'd1,
    PH_COUNT   = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_START   = 4'd5,
    PH_SIZE    = 4'd6,
    PH_CONTENT = 4'd7,
    PH_TRAIL   = 4'd8,
    PH_ERROR   = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  byte_in_field;
    logic [31:0] magic_shift;
    logic [7:0]  running_key;
    logic [7:0]  header_key;
    logic        is_encrypted;
    logic [31:0] value_acc;
    logic [31:0] files_remaining;
    logic [31:0] current_entry;
    logic [31:0] name_remaining;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '0;

  typedef struct packed {
    logic        directory_done;
    logic        archive_error;
    logic        encrypted;
    logic [31:0] field_value;
    logic        value_valid;
    logic [31:0] entry_index;
    phase_t      field_kind;
    logic [7:0]  plain_byte;
  } dec_result_t;

endpackage

// ===== hw/rtl/archive_directory_autokey_decoder_core.sv =====
// ----------------------------------------------------------------------------
// archive_directory_autokey_decoder_core
// Archive directory parser with autokey decryption, one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle while in_tready is high and returns exactly
// one tagged result for each. The parse state is updated in the cycle a byte
// is accepted, so bytes may follow back to back with no gaps; each result is
// registered in the output register, or in the one skid entry while the
// output stalls, so input stays ready until the skid entry fills; throughput
// is one transaction per cycle whenever the sink takes results every cycle.
// ----------------------------------------------------------------------------
module archive_directory_autokey_decoder_core
  import ardec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] operation, [1] first
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] plain_byte, [39:8] entry_index, [40] value_valid,
  // [72:41] field_value, [73] encrypted, [74] archive_error,
  // [75] directory_done, [79:76] zero
  output logic [79:0] out_tdata,
  output logic [3:0]  out_tuser   // [3:0] field_kind
);

  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_result_t res;
  dec_result_t out_r;
  dec_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_fire;
  logic        out_free;

  ardec_step u_step (
    .st        (st_r),
    .operation (in_tuser[0]),
    .data_byte (in_tdata),
    .first     (in_tuser[1]),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && in_fire) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.field_kind;
  assign out_tdata  = {4'b0000, out_r.directory_done, out_r.archive_error,
                       out_r.encrypted, out_r.field_value, out_r.value_valid,
                       out_r.entry_index, out_r.plain_byte};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed or dropped");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.value_valid |-> out_r.field_value == 32'd0)
    else $error("field value present without value_valid");
`endif

endmodule

// ===== hw/rtl/ardec_step.sv =====
// ----------------------------------------------------------------------------
// ardec_step
// One parse step: next decoder state and the tagged result for one byte.
// ----------------------------------------------------------------------------
module ardec_step
  import ardec_pkg::*;
(
  input  dec_state_t  st,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output dec_state_t  st_nxt,
  output dec_result_t res
);

  dec_state_t  s;
  logic [7:0]  o;
  logic [7:0]  key;
  phase_t      kind;
  logic [31:0] idx;
  logic [31:0] val;
  logic        valid;
  logic        done;
  logic [31:0] shifted;
  logic [31:0] acc_full;
  logic [31:0] files_dec;
  logic [31:0] name_dec;

  always_comb begin
    s         = (!operation && first) ? STATE_RESET : st;
    st_nxt    = s;
    o         = data_byte;
    kind      = s.phase;
    idx       = '0;
    val       = '0;
    valid     = 1'b0;
    done      = 1'b0;
    key       = s.running_key;
    shifted   = 32'(data_byte) << {s.byte_in_field, 3'b000};
    acc_full  = '0;
    files_dec = s.files_remaining - 32'd1;
    name_dec  = s.name_remaining - 32'd1;

    if (operation) begin
      key  = first ? s.header_key : s.running_key;
      kind = PH_CONTENT;
      st_nxt.running_key = key;
      if (s.is_encrypted) begin
        o = data_byte ^ key;
        st_nxt.running_key = data_byte + key;
      end
    end else begin
      unique case (s.phase)
        PH_MAGIC: begin
          st_nxt.magic_shift = s.magic_shift | shifted;
          if (s.byte_in_field == FIELD_LAST_BYTE) begin
            st_nxt.byte_in_field = '0;
            valid = 1'b1;
            val   = st_nxt.magic_shift;
            if (st_nxt.magic_shift == MAGIC_ENCRYPTED) begin
              st_nxt.is_encrypted = 1'b1;
              st_nxt.phase        = PH_HEADER;
            end else if (st_nxt.magic_shift == MAGIC_PLAIN) begin
              st_nxt.phase = PH_COUNT;
            end else begin
              st_nxt.phase = PH_ERROR;
            end
            st_nxt.value_acc = '0;
          end else begin
            st_nxt.byte_in_field = s.byte_in_field + 2'd1;
          end
        end
        PH_HEADER, PH_COUNT, PH_NAMELEN, PH_START, PH_SIZE: begin
          if (s.phase == PH_HEADER && s.byte_in_field == 2'd0) begin
            key = data_byte ^ KEY_XOR;
            st_nxt.header_key = key;
          end
          st_nxt.running_key = key;
          if (s.phase != PH_HEADER && s.phase != PH_COUNT) begin
            idx = s.current_entry;
          end
          if (s.is_encrypted) begin
            o = data_byte ^ key;
            st_nxt.running_key = data_byte + key;
          end
          acc_full = s.value_acc | (32'(o) << {s.byte_in_field, 3'b000});
          if (s.byte_in_field == FIELD_LAST_BYTE) begin
            st_nxt.byte_in_field = '0;
            st_nxt.value_acc     = '0;
            valid = 1'b1;
            val   = acc_full;
            unique case (s.phase)
              PH_HEADER: st_nxt.phase = PH_COUNT;
              PH_COUNT: begin
                st_nxt.files_remaining = acc_full;
                st_nxt.current_entry   = '0;
                if (acc_full == 32'd0) begin
                  done = 1'b1;
                  st_nxt.phase = PH_TRAIL;
                end else begin
                  st_nxt.phase = PH_NAMELEN;
                end
              end
              PH_NAMELEN: begin
                st_nxt.name_remaining = acc_full;
                st_nxt.phase = (acc_full == 32'd0) ? PH_START : PH_NAME;
              end
              PH_START: st_nxt.phase = PH_SIZE;
              default: begin
                st_nxt.files_remaining = files_dec;
                if (files_dec == 32'd0) begin
                  done = 1'b1;
                  st_nxt.phase = PH_TRAIL;
                end else begin
                  st_nxt.current_entry = s.current_entry + 32'd1;
                  st_nxt.phase = PH_NAMELEN;
                end
              end
            endcase
          end else begin
            st_nxt.byte_in_field = s.byte_in_field + 2'd1;
            st_nxt.value_acc     = acc_full;
          end
        end
        PH_NAME: begin
          idx = s.current_entry;
          if (s.is_encrypted) begin
            o = data_byte ^ s.running_key;
            st_nxt.running_key = data_byte + s.running_key;
          end
          st_nxt.name_remaining = name_dec;
          if (name_dec == 32'd0) begin
            st_nxt.byte_in_field = '0;
            st_nxt.value_acc     = '0;
            st_nxt.phase         = PH_START;
          end
        end
        PH_ERROR: kind = PH_ERROR;
        default: begin
          kind = PH_TRAIL;
          st_nxt.phase = PH_TRAIL;
        end
      endcase
    end
  end

  always_comb begin
    res.plain_byte     = o;
    res.field_kind     = kind;
    res.entry_index    = idx;
    res.value_valid    = valid;
    res.field_value    = val;
    res.encrypted      = st_nxt.is_encrypted;
    res.archive_error  = (st_nxt.phase == PH_ERROR);
    res.directory_done = done;
  end

endmodule
